### design/mcbs_pkg.sv
// Shared types and codes for the multi-channel blink sequencer.
// No dependencies; imported by every module of the block.
package mcbs_pkg;

  // Config port: two 32-bit registers at byte addresses 0 and 4
  localparam int ADDR_W = 3;
  localparam int DATA_W = 32;
  localparam int MASK_W = 8;

  localparam logic REG_RUN_ENABLE = 1'b0;
  localparam logic REG_CHAN_EN    = 1'b1;

  // Request opcodes
  localparam logic [1:0] OP_TICK  = 2'd0;
  localparam logic [1:0] OP_SET   = 2'd1;
  localparam logic [1:0] OP_QUERY = 2'd2;

  // Channel modes
  localparam logic [2:0] MODE_IDLE    = 3'd0;
  localparam logic [2:0] MODE_ON      = 3'd1;
  localparam logic [2:0] MODE_OFF     = 3'd2;
  localparam logic [2:0] MODE_LIMITED = 3'd3;
  localparam logic [2:0] MODE_ENDLESS = 3'd4;

  typedef enum logic [2:0] {
    ST_IDLE  = 3'b001,
    ST_TICK  = 3'b010,
    ST_QUERY = 3'b100
  } state_e;

  typedef struct packed {
    logic              run_en;
    logic [MASK_W-1:0] chan_en;
  } cfg_t;

  typedef struct packed {
    logic start;
    logic stop;
    logic drop_off;
  } step_ctl_t;

endpackage

### design/multi_channel_blink_sequencer_top.sv
// Top level of the multi-channel blink sequencer: control, count memories.
// Depends on mcbs_pkg, mcbs_cfg_regs and mcbs_blink_step.
//
//  port group     direction  handshake               payload
//  -------------  ---------  ----------------------  ------------------------------
//  request        in         start & !busy           opcode, channel, mode, counts
//  result         out        done_o (one cycle)      masks, status, mode, counts
//  config (APB)   in/out     psel&penable&pwrite     run enable, channel enable mask
//
// Cycles: a tick walks the channels through the count memories one channel per
// cycle; busy stays high for the whole walk and done_o comes as busy drops. Set
// gives its result the next cycle; query after its memory read in ST_QUERY. Tick
// with run enable low and unused opcodes answer the next cycle.
// Reset (rst_ni, async, low) clears modes and reload flags; the count memories
// need no clearing pass since a channel's counts are only used after a set.
// The receiver cannot stall: each result shows for exactly one cycle.
module multi_channel_blink_sequencer_top import mcbs_pkg::*; #(
  parameter int CHANNELS   = 8,
  parameter int COUNT_BITS = 16
) (
  input  logic              clk_i,
  input  logic              rst_ni,
  // configuration port
  input  logic              psel,
  input  logic              penable,
  input  logic              pwrite,
  input  logic [ADDR_W-1:0] paddr,
  input  logic [DATA_W-1:0] pwdata,
  output logic [DATA_W-1:0] prdata,
  output logic              pready,
  // request
  input  logic              start,
  output logic              busy,
  input  logic [1:0]        opcode_i,
  input  logic [2:0]        channel_i,
  input  logic [2:0]        mode_i,
  input  logic [15:0]       repeat_count_i,
  input  logic [15:0]       on_ticks_i,
  input  logic [15:0]       off_ticks_i,
  input  logic [15:0]       gap_ticks_i,
  // result
  output logic              done_o,
  output logic [7:0]        start_mask_o,
  output logic [7:0]        stop_mask_o,
  output logic              status_o,
  output logic [2:0]        channel_mode_o,
  output logic [15:0]       out_repeat_o,
  output logic [15:0]       out_on_o,
  output logic [15:0]       out_off_o,
  output logic [15:0]       out_gap_o
);

  localparam int CB = COUNT_BITS;
  localparam int DW = 4 * COUNT_BITS;
  localparam int CW = (CHANNELS > 1) ? $clog2(CHANNELS) : 1;
  localparam int IW = $clog2(CHANNELS + 1);

  cfg_t cfg;

  mcbs_cfg_regs u_cfg (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .pready  (pready),
    .cfg_o   (cfg)
  );

  // Per-channel enable; channels past the 8-bit mask never act
  logic [CHANNELS-1:0] en_vec;
  for (genvar c = 0; c < CHANNELS; c++) begin : g_en
    if (c < MASK_W) begin : g_in
      assign en_vec[c] = cfg.chan_en[c];
    end else begin : g_out
      assign en_vec[c] = 1'b0;
    end
  end

  // ---------------------------------------------------------------------------
  // Control state
  // ---------------------------------------------------------------------------
  state_e            state_q, state_d;
  logic [IW-1:0]     issue_q, issue_d;      // next channel to read
  logic              p_vld_q, p_vld_d;      // read data valid for p_idx_q
  logic [CW-1:0]     p_idx_q, p_idx_d;
  logic [CW-1:0]     q_ch_q, q_ch_d;
  logic [MASK_W-1:0] acc_start_q, acc_start_d;
  logic [MASK_W-1:0] acc_stop_q, acc_stop_d;

  // Mode and reload flags live in flops so that reset clears them at once
  logic [2:0]          chan_mode_q [CHANNELS];
  logic [CHANNELS-1:0] reload_q;
  logic                mode_we;
  logic [CW-1:0]       mode_wa;
  logic [2:0]          mode_wd;
  logic                reload_set, reload_clr;
  logic [CW-1:0]       mode_ra;
  logic [2:0]          mode_rd;

  // Count memories: set counts (written by set) and working counts (ticks)
  logic [DW-1:0] set_mem  [CHANNELS];
  logic [DW-1:0] work_mem [CHANNELS];
  logic          set_we, set_re, work_we, work_re;
  logic [CW-1:0] set_ra;
  logic [DW-1:0] set_wd, set_rdata_q, work_rdata_q, work_wd;

  // Result registers
  logic              done_d, done_q;
  logic [MASK_W-1:0] res_start_d, res_start_q, res_stop_d, res_stop_q;
  logic              res_status_d, res_status_q;
  logic [2:0]        res_mode_d, res_mode_q;
  logic [15:0]       res_rep_d, res_rep_q, res_on_d, res_on_q;
  logic [15:0]       res_off_d, res_off_q, res_gap_d, res_gap_q;

  logic          accept;
  logic          ch_ok;
  logic [CW-1:0] ch_idx;
  logic          set_reject;
  logic          last_stage;
  step_ctl_t     step_ctl;
  logic          act_start, act_stop;

  assign busy   = (state_q != ST_IDLE);
  assign accept = start && !busy;
  assign ch_ok  = int'(channel_i) < CHANNELS;
  assign ch_idx = CW'(channel_i);
  assign set_reject = !cfg.run_en || !ch_ok || (mode_i > MODE_ENDLESS) ||
                      !cfg.chan_en[channel_i];

  assign mode_ra = (state_q == ST_TICK) ? p_idx_q : q_ch_q;
  assign mode_rd = chan_mode_q[mode_ra];

  assign set_wd = {CB'(repeat_count_i), CB'(on_ticks_i), CB'(off_ticks_i),
                   CB'(gap_ticks_i)};

  mcbs_blink_step #(.COUNT_BITS(COUNT_BITS)) u_step (
    .limited_i  (mode_rd == MODE_LIMITED),
    .reload_i   (reload_q[p_idx_q]),
    .set_cnt_i  (set_rdata_q),
    .work_cnt_i (work_rdata_q),
    .work_cnt_o (work_wd),
    .ctl_o      (step_ctl)
  );

  // The tick walk reads channel n+1 while writing back channel n; the two never
  // hit the same entry, so no forwarding is needed.
  assign last_stage = p_vld_q && (issue_q == IW'(CHANNELS));

  always_comb begin
    state_d     = state_q;
    issue_d     = issue_q;
    p_vld_d     = 1'b0;
    p_idx_d     = p_idx_q;
    q_ch_d      = q_ch_q;
    acc_start_d = acc_start_q;
    acc_stop_d  = acc_stop_q;
    mode_we     = 1'b0;
    mode_wa     = ch_idx;
    mode_wd     = mode_i;
    reload_set  = 1'b0;
    reload_clr  = 1'b0;
    set_we      = 1'b0;
    set_re      = 1'b0;
    set_ra      = ch_idx;
    work_re     = 1'b0;
    work_we     = 1'b0;
    act_start   = 1'b0;
    act_stop    = 1'b0;
    done_d       = 1'b0;
    res_start_d  = '0;
    res_stop_d   = '0;
    res_status_d = 1'b0;
    res_mode_d   = MODE_IDLE;
    res_rep_d    = '0;
    res_on_d     = '0;
    res_off_d    = '0;
    res_gap_d    = '0;

    unique case (state_q)
      ST_IDLE: begin
        if (accept) begin
          unique case (opcode_i)
            OP_TICK: begin
              if (cfg.run_en) begin
                state_d     = ST_TICK;
                issue_d     = '0;
                acc_start_d = '0;
                acc_stop_d  = '0;
              end else begin
                done_d = 1'b1;
              end
            end
            OP_SET: begin
              done_d = 1'b1;
              if (set_reject) begin
                res_status_d = 1'b1;
              end else begin
                set_we     = 1'b1;
                mode_we    = 1'b1;
                reload_set = 1'b1;
              end
            end
            OP_QUERY: begin
              if (ch_ok) begin
                set_re  = 1'b1;
                q_ch_d  = ch_idx;
                state_d = ST_QUERY;
              end else begin
                done_d = 1'b1;
              end
            end
            default: done_d = 1'b1;
          endcase
        end
      end

      ST_TICK: begin
        // read side
        if (issue_q != IW'(CHANNELS)) begin
          set_re  = 1'b1;
          work_re = 1'b1;
          set_ra  = issue_q[CW-1:0];
          p_vld_d = 1'b1;
          p_idx_d = issue_q[CW-1:0];
          issue_d = issue_q + IW'(1);
        end
        // modify / write-back side
        if (p_vld_q && en_vec[p_idx_q]) begin
          unique case (mode_rd)
            MODE_ON:  act_start = 1'b1;
            MODE_OFF: act_stop  = 1'b1;
            MODE_LIMITED, MODE_ENDLESS: begin
              work_we    = 1'b1;
              reload_clr = 1'b1;
              act_start  = step_ctl.start;
              act_stop   = step_ctl.stop;
              if (step_ctl.drop_off) begin
                mode_we = 1'b1;
                mode_wa = p_idx_q;
                mode_wd = MODE_OFF;
              end
            end
            default: ;
          endcase
        end
        acc_start_d = acc_start_q | (MASK_W'(act_start) << p_idx_q);
        acc_stop_d  = acc_stop_q  | (MASK_W'(act_stop)  << p_idx_q);
        if (last_stage) begin
          done_d      = 1'b1;
          res_start_d = acc_start_d;
          res_stop_d  = acc_stop_d;
          state_d     = ST_IDLE;
        end
      end

      ST_QUERY: begin
        done_d     = 1'b1;
        res_mode_d = mode_rd;
        if (mode_rd == MODE_LIMITED || mode_rd == MODE_ENDLESS) begin
          res_rep_d = 16'(set_rdata_q[DW-1 -: CB]);
          res_on_d  = 16'(set_rdata_q[3*CB-1 -: CB]);
          res_off_d = 16'(set_rdata_q[2*CB-1 -: CB]);
          res_gap_d = 16'(set_rdata_q[CB-1:0]);
        end
        state_d = ST_IDLE;
      end

      default: state_d = ST_IDLE;
    endcase
  end

  // Control flops
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_IDLE;
      issue_q     <= '0;
      p_vld_q     <= 1'b0;
      p_idx_q     <= '0;
      q_ch_q      <= '0;
      acc_start_q <= '0;
      acc_stop_q  <= '0;
      done_q      <= 1'b0;
      reload_q    <= '0;
      for (int i = 0; i < CHANNELS; i++) begin
        chan_mode_q[i] <= MODE_IDLE;
      end
    end else begin
      state_q     <= state_d;
      issue_q     <= issue_d;
      p_vld_q     <= p_vld_d;
      p_idx_q     <= p_idx_d;
      q_ch_q      <= q_ch_d;
      acc_start_q <= acc_start_d;
      acc_stop_q  <= acc_stop_d;
      done_q      <= done_d;
      if (mode_we) begin
        chan_mode_q[mode_wa] <= mode_wd;
      end
      if (reload_set) begin
        reload_q[ch_idx] <= 1'b1;
      end
      if (reload_clr) begin
        reload_q[p_idx_q] <= 1'b0;
      end
    end
  end

  // Count memories, registered read
  always_ff @(posedge clk_i) begin
    if (set_we) begin
      set_mem[ch_idx] <= set_wd;
    end
    if (set_re) begin
      set_rdata_q <= set_mem[set_ra];
    end
    if (work_we) begin
      work_mem[p_idx_q] <= work_wd;
    end
    if (work_re) begin
      work_rdata_q <= work_mem[issue_q[CW-1:0]];
    end
  end

  // Result payload: zero outside the strobe cycle
  always_ff @(posedge clk_i) begin
    res_start_q  <= res_start_d;
    res_stop_q   <= res_stop_d;
    res_status_q <= res_status_d;
    res_mode_q   <= res_mode_d;
    res_rep_q    <= res_rep_d;
    res_on_q     <= res_on_d;
    res_off_q    <= res_off_d;
    res_gap_q    <= res_gap_d;
  end

  assign done_o         = done_q;
  assign start_mask_o   = res_start_q;
  assign stop_mask_o    = res_stop_q;
  assign status_o       = res_status_q;
  assign channel_mode_o = res_mode_q;
  assign out_repeat_o   = res_rep_q;
  assign out_on_o       = res_on_q;
  assign out_off_o      = res_off_q;
  assign out_gap_o      = res_gap_q;

  // ---------------------------------------------------------------------------
  // Assertions
  // ---------------------------------------------------------------------------
  a_done_idle: assert property (@(posedge clk_i) disable iff (!rst_ni)
    done_o |-> !busy)
    else $error("result strobe while busy");

  a_set_one_cycle: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (start && !busy && opcode_i == OP_SET) |=> done_o)
    else $error("set request did not answer next cycle");

  a_masks_disjoint: assert property (@(posedge clk_i) disable iff (!rst_ni)
    done_o |-> ((start_mask_o & stop_mask_o) == '0))
    else $error("channel both starts and stops");

  a_stage_in_tick: assert property (@(posedge clk_i) disable iff (!rst_ni)
    p_vld_q |-> (state_q == ST_TICK))
    else $error("channel write-back outside tick walk");

endmodule

### design/mcbs_cfg_regs.sv
// APB-style configuration registers: run enable and channel enable mask.
// Depends on mcbs_pkg.
module mcbs_cfg_regs import mcbs_pkg::*; (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              psel,
  input  logic              penable,
  input  logic              pwrite,
  input  logic [ADDR_W-1:0] paddr,
  input  logic [DATA_W-1:0] pwdata,
  output logic [DATA_W-1:0] prdata,
  output logic              pready,
  output cfg_t              cfg_o
);

  logic              run_en_q, run_en_d;
  logic [MASK_W-1:0] chan_en_q, chan_en_d;
  logic              wr_en;
  logic              reg_sel;

  assign pready  = 1'b1;
  assign reg_sel = paddr[ADDR_W-1];
  assign wr_en   = psel && penable && pwrite;

  always_comb begin
    run_en_d  = run_en_q;
    chan_en_d = chan_en_q;
    if (wr_en) begin
      unique case (reg_sel)
        REG_RUN_ENABLE: run_en_d  = pwdata[0];
        REG_CHAN_EN:    chan_en_d = pwdata[MASK_W-1:0];
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      run_en_q  <= 1'b0;
      chan_en_q <= '0;
    end else begin
      run_en_q  <= run_en_d;
      chan_en_q <= chan_en_d;
    end
  end

  always_comb begin
    unique case (reg_sel)
      REG_RUN_ENABLE: prdata = {{(DATA_W-1){1'b0}}, run_en_q};
      REG_CHAN_EN:    prdata = {{(DATA_W-MASK_W){1'b0}}, chan_en_q};
      default:        prdata = '0;
    endcase
  end

  assign cfg_o.run_en  = run_en_q;
  assign cfg_o.chan_en = chan_en_q;

endmodule

### design/mcbs_blink_step.sv
// One tick of a blink channel: reload, period counting, repeat countdown.
// Depends on mcbs_pkg. Counts packed as {repeat, on, off, gap}.
module mcbs_blink_step import mcbs_pkg::*; #(
  parameter int COUNT_BITS = 16
) (
  input  logic                    limited_i,
  input  logic                    reload_i,
  input  logic [4*COUNT_BITS-1:0] set_cnt_i,
  input  logic [4*COUNT_BITS-1:0] work_cnt_i,
  output logic [4*COUNT_BITS-1:0] work_cnt_o,
  output step_ctl_t               ctl_o
);

  localparam int CB = COUNT_BITS;

  logic [4*CB-1:0] w;
  logic [CB-1:0]   w_rep, w_on, w_off, w_gap;
  logic [CB-1:0]   s_on, s_off, s_gap;
  logic [CB-1:0]   n_rep, n_on, n_off, n_gap;

  // A pending reload takes the freshly set counts
  assign w = reload_i ? set_cnt_i : work_cnt_i;
  assign {w_rep, w_on, w_off, w_gap} = w;
  assign s_on  = set_cnt_i[3*CB-1 -: CB];
  assign s_off = set_cnt_i[2*CB-1 -: CB];
  assign s_gap = set_cnt_i[CB-1:0];

  always_comb begin
    ctl_o = '0;
    n_rep = w_rep;
    n_on  = w_on;
    n_off = w_off;
    n_gap = w_gap;
    if (limited_i && w_rep == '0) begin
      ctl_o.drop_off = 1'b1;
    end else begin
      if (w_on != '0) begin
        ctl_o.start = 1'b1;
        n_on        = w_on - CB'(1);
      end else if (w_off != '0) begin
        ctl_o.stop = 1'b1;
        n_off      = w_off - CB'(1);
      end else if (w_gap != '0) begin
        n_gap = w_gap - CB'(1);
      end
      // period complete
      if (n_on == '0 && n_off == '0 && n_gap == '0) begin
        if (limited_i) begin
          n_rep = w_rep - CB'(1);
        end
        n_on  = s_on;
        n_off = s_off;
        n_gap = s_gap;
      end
    end
  end

  assign work_cnt_o = {n_rep, n_on, n_off, n_gap};

endmodule

### dv/mcbs_checker.sv
`timescale 1ns / 1ps
// Checker for the multi-channel blink sequencer: tracks register writes and requests,
// predicts each result and compares it with the block's output. Depends on mcbs_pkg.
module mcbs_checker import mcbs_pkg::*; (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              psel_i,
  input  logic              penable_i,
  input  logic              pwrite_i,
  input  logic              pready_i,
  input  logic [ADDR_W-1:0] paddr_i,
  input  logic [DATA_W-1:0] pwdata_i,
  input  logic              start_i,
  input  logic              busy_i,
  input  logic [1:0]        opcode_i,
  input  logic [2:0]        channel_i,
  input  logic [2:0]        mode_i,
  input  logic [15:0]       repeat_count_i,
  input  logic [15:0]       on_ticks_i,
  input  logic [15:0]       off_ticks_i,
  input  logic [15:0]       gap_ticks_i,
  input  logic              done_i,
  input  logic [7:0]        start_mask_i,
  input  logic [7:0]        stop_mask_i,
  input  logic              status_i,
  input  logic [2:0]        channel_mode_i,
  input  logic [15:0]       out_repeat_i,
  input  logic [15:0]       out_on_i,
  input  logic [15:0]       out_off_i,
  input  logic [15:0]       out_gap_i,
  output int                fail_count_o,
  output int                pending_count_o
);

  localparam int   NUM_CH          = 8;
  localparam logic STATUS_OK       = 1'b0;
  localparam logic STATUS_REJECTED = 1'b1;

  typedef struct packed {
    logic [15:0] rep;
    logic [15:0] on;
    logic [15:0] off;
    logic [15:0] gap;
  } blink_counts_t;

  typedef struct packed {
    logic [7:0]    start_mask;
    logic [7:0]    stop_mask;
    logic          status;
    logic [2:0]    mode;
    blink_counts_t counts;
  } blink_result_t;

  typedef enum logic [1:0] {
    ACT_NONE,
    ACT_START,
    ACT_STOP
  } action_e;

  logic [2:0]        mode_q   [NUM_CH];
  logic              reload_q [NUM_CH];
  blink_counts_t     set_q    [NUM_CH];
  blink_counts_t     work_q   [NUM_CH];
  logic              run_en_q;
  logic [MASK_W-1:0] chan_en_q;
  blink_result_t     due_results [$];
  int                mismatches;

  // One tick of a blink channel: reload, then on, off, gap phases
  function automatic action_e step_blink(int c, logic limited);
    action_e act = ACT_NONE;
    if (reload_q[c]) begin
      reload_q[c] = 1'b0;
      work_q[c]   = set_q[c];
    end
    if (limited && work_q[c].rep == 16'd0) begin
      mode_q[c] = MODE_OFF;
      return ACT_NONE;
    end
    if (work_q[c].on != 16'd0) begin
      act = ACT_START;
      work_q[c].on--;
    end else if (work_q[c].off != 16'd0) begin
      act = ACT_STOP;
      work_q[c].off--;
    end else if (work_q[c].gap != 16'd0) begin
      work_q[c].gap--;
    end
    if (work_q[c].on == 16'd0 && work_q[c].off == 16'd0 && work_q[c].gap == 16'd0) begin
      if (limited) work_q[c].rep--;
      work_q[c].on  = set_q[c].on;
      work_q[c].off = set_q[c].off;
      work_q[c].gap = set_q[c].gap;
    end
    return act;
  endfunction

  function automatic blink_result_t blink_response(logic [1:0] op, logic [2:0] ch,
                                                   logic [2:0] mode, blink_counts_t cnt);
    blink_result_t res;
    action_e       act;
    res = '0;
    case (op)
      OP_TICK: begin
        if (run_en_q) begin
          for (int c = 0; c < NUM_CH; c++) begin
            if (chan_en_q[c]) begin
              case (mode_q[c])
                MODE_ON:      act = ACT_START;
                MODE_OFF:     act = ACT_STOP;
                MODE_LIMITED: act = step_blink(c, 1'b1);
                MODE_ENDLESS: act = step_blink(c, 1'b0);
                default:      act = ACT_NONE;
              endcase
              res.start_mask[c] = (act == ACT_START);
              res.stop_mask[c]  = (act == ACT_STOP);
            end
          end
        end
      end
      OP_SET: begin
        if (!run_en_q || mode > MODE_ENDLESS || !chan_en_q[ch]) begin
          res.status = STATUS_REJECTED;
        end else begin
          res.status   = STATUS_OK;
          reload_q[ch] = 1'b1;
          mode_q[ch]   = mode;
          set_q[ch]    = cnt;
        end
      end
      OP_QUERY: begin
        res.mode = mode_q[ch];
        if (mode_q[ch] == MODE_LIMITED || mode_q[ch] == MODE_ENDLESS) res.counts = set_q[ch];
      end
      default: ;
    endcase
    return res;
  endfunction

  function automatic void check_field(string name, logic [15:0] want, logic [15:0] got);
    if (got !== want) begin
      $error("%s mismatch: expected 0x%0h, got 0x%0h", name, want, got);
      mismatches++;
    end
  endfunction

  always @(posedge clk_i or negedge rst_ni) begin
    blink_result_t want;
    if (!rst_ni) begin
      for (int c = 0; c < NUM_CH; c++) begin
        mode_q[c]   = MODE_IDLE;
        reload_q[c] = 1'b0;
        set_q[c]    = '0;
        work_q[c]   = '0;
      end
      run_en_q   = 1'b0;
      chan_en_q  = '0;
      mismatches = 0;
      due_results.delete();
      fail_count_o    <= 0;
      pending_count_o <= 0;
    end else begin
      // results first: a result and the next request may share an edge
      if (done_i) begin
        if (due_results.size() == 0) begin
          $error("result with no request outstanding");
          mismatches++;
        end else begin
          want = due_results.pop_front();
          check_field("start_mask", 16'(want.start_mask), 16'(start_mask_i));
          check_field("stop_mask", 16'(want.stop_mask), 16'(stop_mask_i));
          check_field("status", 16'(want.status), 16'(status_i));
          check_field("channel_mode", 16'(want.mode), 16'(channel_mode_i));
          check_field("out_repeat", want.counts.rep, out_repeat_i);
          check_field("out_on", want.counts.on, out_on_i);
          check_field("out_off", want.counts.off, out_off_i);
          check_field("out_gap", want.counts.gap, out_gap_i);
        end
      end
      if (psel_i && penable_i && pwrite_i && pready_i) begin
        if (paddr_i[ADDR_W-1:2] == REG_RUN_ENABLE) run_en_q = pwdata_i[0];
        else if (paddr_i[ADDR_W-1:2] == REG_CHAN_EN) chan_en_q = pwdata_i[MASK_W-1:0];
      end
      if (start_i && !busy_i) begin
        due_results.push_back(blink_response(opcode_i, channel_i, mode_i,
            blink_counts_t'({repeat_count_i, on_ticks_i, off_ticks_i, gap_ticks_i})));
      end
      fail_count_o    <= mismatches;
      pending_count_o <= due_results.size();
    end
  end

endmodule

### dv/multi_channel_blink_sequencer_top_tb.sv
`timescale 1ns / 1ps
// Testbench top for the multi-channel blink sequencer: clock, reset, register writes
// and request stimulus, verdict. Depends on mcbs_pkg, the block and mcbs_checker.
module multi_channel_blink_sequencer_top_tb;
  import mcbs_pkg::*;

  localparam logic [1:0]        OP_UNUSED       = 2'd3;
  localparam logic [ADDR_W-1:0] ADDR_RUN_ENABLE = {REG_RUN_ENABLE, 2'b00};
  localparam logic [ADDR_W-1:0] ADDR_CHAN_EN    = {REG_CHAN_EN, 2'b00};
  // longest quiet stretch: sender gap, a full channel walk and a register update
  localparam int STALL_LIMIT   = 1000;
  localparam int SETTLE_CYCLES = 20;

  logic              clk_i          = 1'b0;
  logic              rst_ni         = 1'b0;
  logic              psel           = 1'b0;
  logic              penable        = 1'b0;
  logic              pwrite         = 1'b0;
  logic [ADDR_W-1:0] paddr          = '0;
  logic [DATA_W-1:0] pwdata         = '0;
  logic [DATA_W-1:0] prdata;
  logic              pready;
  logic              start          = 1'b0;
  logic              busy;
  logic [1:0]        opcode_i       = '0;
  logic [2:0]        channel_i      = '0;
  logic [2:0]        mode_i         = '0;
  logic [15:0]       repeat_count_i = '0;
  logic [15:0]       on_ticks_i     = '0;
  logic [15:0]       off_ticks_i    = '0;
  logic [15:0]       gap_ticks_i    = '0;
  logic              done_o;
  logic [7:0]        start_mask_o;
  logic [7:0]        stop_mask_o;
  logic              status_o;
  logic [2:0]        channel_mode_o;
  logic [15:0]       out_repeat_o;
  logic [15:0]       out_on_o;
  logic [15:0]       out_off_o;
  logic [15:0]       out_gap_o;
  int                fail_count;
  int                pending_count;
  int                stall_cycles   = 0;

  always #4 clk_i = ~clk_i;

  multi_channel_blink_sequencer_top dut (
    .clk_i, .rst_ni,
    .psel, .penable, .pwrite, .paddr, .pwdata, .prdata, .pready,
    .start, .busy,
    .opcode_i, .channel_i, .mode_i, .repeat_count_i, .on_ticks_i, .off_ticks_i, .gap_ticks_i,
    .done_o, .start_mask_o, .stop_mask_o, .status_o, .channel_mode_o,
    .out_repeat_o, .out_on_o, .out_off_o, .out_gap_o
  );

  mcbs_checker u_check (
    .clk_i, .rst_ni,
    .psel_i(psel), .penable_i(penable), .pwrite_i(pwrite), .pready_i(pready),
    .paddr_i(paddr), .pwdata_i(pwdata),
    .start_i(start), .busy_i(busy),
    .opcode_i, .channel_i, .mode_i, .repeat_count_i, .on_ticks_i, .off_ticks_i, .gap_ticks_i,
    .done_i(done_o), .start_mask_i(start_mask_o), .stop_mask_i(stop_mask_o),
    .status_i(status_o), .channel_mode_i(channel_mode_o),
    .out_repeat_i(out_repeat_o), .out_on_i(out_on_o), .out_off_i(out_off_o),
    .out_gap_i(out_gap_o),
    .fail_count_o(fail_count), .pending_count_o(pending_count)
  );

  // Watchdog: any accepted request or result restarts the count
  always @(posedge clk_i) begin
    if ((start && !busy) || done_o) begin
      stall_cycles <= 0;
    end else if (stall_cycles == STALL_LIMIT) begin
      $display("multi_channel_blink_sequencer_top verification failed");
      $finish;
    end else begin
      stall_cycles <= stall_cycles + 1;
    end
  end

  // Hold one request on the port until the block takes it
  task automatic send_request(logic [1:0] op, logic [2:0] ch, logic [2:0] mode,
                              logic [15:0] rep, logic [15:0] on_n, logic [15:0] off_n,
                              logic [15:0] gap_n);
    opcode_i       <= op;
    channel_i      <= ch;
    mode_i         <= mode;
    repeat_count_i <= rep;
    on_ticks_i     <= on_n;
    off_ticks_i    <= off_n;
    gap_ticks_i    <= gap_n;
    start          <= 1'b1;
    do @(posedge clk_i); while (busy);
  endtask

  // Wait until every outstanding request has produced its result
  task automatic drain();
    do @(posedge clk_i); while (pending_count != 0);
  endtask

  task automatic apb_write(logic [ADDR_W-1:0] addr, logic [DATA_W-1:0] data);
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= 1'b1;
    paddr   <= addr;
    pwdata  <= data;
    @(posedge clk_i);
    penable <= 1'b1;
    do @(posedge clk_i); while (!pready);
    psel    <= 1'b0;
    penable <= 1'b0;
    pwrite  <= 1'b0;
    @(posedge clk_i);
  endtask

  // Registers change only with the block idle; upper data bits carry noise
  task automatic configure(logic run, logic [MASK_W-1:0] mask);
    logic [DATA_W-1:0] word;
    start <= 1'b0;
    drain();
    repeat (3) @(posedge clk_i);
    word    = $urandom;
    word[0] = run;
    apb_write(ADDR_RUN_ENABLE, word);
    word               = $urandom;
    word[MASK_W-1:0]   = mask;
    apb_write(ADDR_CHAN_EN, word);
  endtask

  // Mostly short counts so periods and repeats run out; now and then a full-width value
  function automatic logic [15:0] random_count(int low_max);
    return ($urandom_range(0, 9) == 0) ? 16'($urandom) : 16'($urandom_range(0, low_max));
  endfunction

  task automatic random_request();
    int         pick;
    logic [1:0] op;
    logic [2:0] mode;
    pick = $urandom_range(0, 99);
    if (pick < 55)      op = OP_TICK;
    else if (pick < 80) op = OP_SET;
    else if (pick < 95) op = OP_QUERY;
    else                op = OP_UNUSED;
    pick = $urandom_range(0, 19);
    if (pick < 2)      mode = 3'($urandom_range(5, 7));   // illegal modes, rejected
    else if (pick < 6) mode = 3'($urandom_range(0, 2));
    else               mode = pick[0] ? MODE_LIMITED : MODE_ENDLESS;
    send_request(op, 3'($urandom_range(0, 7)), mode, random_count(4),
                 random_count(3), random_count(3), random_count(3));
  endtask

  // Bursts of back-to-back requests with random gaps; sometimes wait for all results
  task automatic run_phase(logic run, logic [MASK_W-1:0] mask, int count);
    int sent;
    int burst;
    sent = 0;
    configure(run, mask);
    while (sent < count) begin
      burst = ($urandom_range(0, 7) == 0) ? $urandom_range(30, 60) : $urandom_range(1, 8);
      repeat (burst) begin
        if (sent < count) begin
          random_request();
          sent++;
        end
      end
      start <= 1'b0;
      if ($urandom_range(0, 19) == 0) drain();
      else repeat ($urandom_range(1, 12)) @(posedge clk_i);
    end
  endtask

  initial begin
    repeat (5) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // Out of reset: not running, no channel enabled
    send_request(OP_TICK, 3'd0, MODE_IDLE, 16'd0, 16'd0, 16'd0, 16'd0);
    send_request(OP_SET, 3'd0, MODE_LIMITED, 16'd1, 16'd1, 16'd1, 16'd1);
    send_request(OP_QUERY, 3'd0, MODE_IDLE, 16'd0, 16'd0, 16'd0, 16'd0);

    // Channels enabled but not running: set still rejected, tick quiet
    configure(1'b0, 8'hFF);
    send_request(OP_SET, 3'd1, MODE_ON, 16'd0, 16'd0, 16'd0, 16'd0);
    send_request(OP_TICK, 3'd0, MODE_IDLE, 16'd0, 16'd0, 16'd0, 16'd0);

    // Running: one channel per mode, limited with no repeats, all-zero endless,
    // all-ones counts, illegal modes
    configure(1'b1, 8'hFF);
    send_request(OP_SET, 3'd0, MODE_ON, 16'd5, 16'd6, 16'd7, 16'd8);
    send_request(OP_SET, 3'd1, MODE_OFF, 16'd0, 16'd0, 16'd0, 16'd0);
    send_request(OP_SET, 3'd2, MODE_LIMITED, 16'd2, 16'd1, 16'd1, 16'd1);
    send_request(OP_SET, 3'd3, MODE_ENDLESS, 16'd0, 16'd2, 16'd0, 16'd1);
    send_request(OP_SET, 3'd4, MODE_LIMITED, 16'd0, 16'd3, 16'd3, 16'd3);
    send_request(OP_SET, 3'd5, MODE_ENDLESS, 16'd0, 16'd0, 16'd0, 16'd0);
    send_request(OP_SET, 3'd6, MODE_LIMITED, 16'hFFFF, 16'hFFFF, 16'hFFFF, 16'hFFFF);
    send_request(OP_SET, 3'd7, 3'd7, 16'd1, 16'd1, 16'd1, 16'd1);
    send_request(OP_SET, 3'd7, 3'd5, 16'd1, 16'd1, 16'd1, 16'd1);
    repeat (6) send_request(OP_TICK, 3'd0, MODE_IDLE, 16'd0, 16'd0, 16'd0, 16'd0);
    send_request(OP_QUERY, 3'd6, MODE_IDLE, 16'd0, 16'd0, 16'd0, 16'd0);
    send_request(OP_QUERY, 3'd0, MODE_IDLE, 16'd0, 16'd0, 16'd0, 16'd0);
    send_request(OP_QUERY, 3'd4, MODE_IDLE, 16'd0, 16'd0, 16'd0, 16'd0);
    send_request(OP_UNUSED, 3'd7, 3'd7, 16'hFFFF, 16'hFFFF, 16'hFFFF, 16'hFFFF);
    // reload at a period boundary, once the repeats are used up
    send_request(OP_SET, 3'd2, MODE_LIMITED, 16'd1, 16'd0, 16'd0, 16'd0);
    send_request(OP_TICK, 3'd0, MODE_IDLE, 16'd0, 16'd0, 16'd0, 16'd0);

    // Random phases over several register settings, extremes among them
    run_phase(1'b1, 8'hFF, 200);
    run_phase(1'b1, MASK_W'($urandom_range(1, 254)), 150);
    run_phase(1'b1, 8'h00, 40);
    run_phase(1'b0, MASK_W'($urandom_range(0, 255)), 40);
    run_phase(1'b1, 8'h55, 150);
    run_phase(1'b1, 8'hAA, 150);
    run_phase(1'b1, 8'hFF, 150);

    drain();
    repeat (SETTLE_CYCLES) @(posedge clk_i);
    if (fail_count == 0 && pending_count == 0) begin
      $display("multi_channel_blink_sequencer_top verification clean");
    end else begin
      $display("multi_channel_blink_sequencer_top verification failed");
    end
    $finish;
  end

endmodule
